### src/ppart_pkg.sv
package ppart_pkg;

  localparam int DEPTH       = 64;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     last_out;
    logic                     overflow;
  } out_item_t;

  // Command from the front end to the back end.
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     store;
    logic                     last;
    logic                     overflow;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

### src/ppart_front.sv
module ppart_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppart_pkg::in_item_t in_item,
  input  logic                q_full,
  output logic                q_push,
  output ppart_pkg::cmd_t     q_cmd
);
  import ppart_pkg::*;

  logic [CNT_W-1:0] count;
  logic             ovf_seen;
  logic             has_room;

  assign has_room = count < CNT_W'(DEPTH);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.value    = in_item.value;
    q_cmd.store    = has_room;
    q_cmd.last     = in_item.last_in;
    q_cmd.overflow = ovf_seen || !has_room;
  end

  // The front end tracks its own fill level so that it can tag each word
  // as stored or dropped without waiting for the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (q_push) begin
      if (in_item.last_in) begin
        count    <= '0;
        ovf_seen <= 1'b0;
      end else if (has_room) begin
        count <= count + CNT_W'(1);
      end else begin
        ovf_seen <= 1'b1;
      end
    end
  end

endmodule

### src/ppart_queue.sv
module ppart_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  ppart_pkg::cmd_t          push_cmd,
  input  logic                     pop,
  output ppart_pkg::cmd_t          head,
  output ppart_pkg::queue_status_t status
);
  import ppart_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

### src/ppart_back.sv
module ppart_back (
  input  logic                     clk,
  input  logic                     rst,
  input  ppart_pkg::queue_status_t q_status,
  input  ppart_pkg::cmd_t          q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ppart_pkg::out_item_t     out_item
);
  import ppart_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PRD   = 6'b000010,
    ST_PEVAL = 6'b000100,
    ST_PSWAP = 6'b001000,
    ST_ERD   = 6'b010000,
    ST_ELD   = 6'b100000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  len;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [ADDR_W-1:0] idx;
  logic              run_ovf;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a;

  logic              even_a;
  logic              even_b;
  logic              swap;
  logic              step_lo;
  logic              step_hi;
  logic [ADDR_W-1:0] lo_next;
  logic [ADDR_W-1:0] hi_next;
  logic              more;
  logic [CNT_W-1:0]  len_now;
  logic              idx_last;
  logic              out_load;

  assign q_pop    = (state == ST_IDLE) && !q_status.empty;
  assign len_now  = count + CNT_W'(q_head.store);

  assign even_a   = !rdata_a[0];
  assign even_b   = !rdata_b[0];
  assign swap     = even_a && !even_b;

  // A swap is written in two halves on the single write port (ST_PEVAL, then
  // ST_PSWAP); both pointers move once the second half is written.
  assign step_lo  = (state == ST_PSWAP) || ((state == ST_PEVAL) && !swap && !even_a);
  assign step_hi  = (state == ST_PSWAP) || ((state == ST_PEVAL) && !swap && even_b);
  assign lo_next  = lo + ADDR_W'(step_lo);
  assign hi_next  = hi - ADDR_W'(step_hi);
  assign more     = lo_next < hi_next;

  assign idx_last = (CNT_W'(idx) + CNT_W'(1)) == len;
  assign out_load = (state == ST_ELD) && (!out_valid || out_ready);

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = lo;
    wr_data   = rdata_b;
    rd_en     = 1'b0;
    rd_addr_a = lo;
    case (state)
      ST_IDLE: begin
        if (q_pop && q_head.store) begin
          wr_en   = 1'b1;
          wr_addr = count[ADDR_W-1:0];
          wr_data = q_head.value;
        end
      end
      ST_PRD: begin
        rd_en = 1'b1;
      end
      ST_PEVAL: begin
        wr_en = swap;
      end
      ST_PSWAP: begin
        wr_en   = 1'b1;
        wr_addr = hi;
        wr_data = rdata_a;
      end
      ST_ERD: begin
        rd_en     = 1'b1;
        rd_addr_a = idx;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_a <= mem[rd_addr_a];
      rdata_b <= mem[hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_head.last) begin
              count   <= '0;
              len     <= len_now;
              run_ovf <= q_head.overflow;
              lo      <= '0;
              hi      <= ADDR_W'(len_now - CNT_W'(1));
              idx     <= '0;
              if (len_now > CNT_W'(1)) begin
                state <= ST_PRD;
              end else if (len_now == CNT_W'(1)) begin
                state <= ST_ERD;
              end
            end else begin
              count <= len_now;
            end
          end
        end
        ST_PRD: begin
          state <= ST_PEVAL;
        end
        ST_PEVAL, ST_PSWAP: begin
          if ((state == ST_PEVAL) && swap) begin
            state <= ST_PSWAP;
          end else begin
            lo    <= lo_next;
            hi    <= hi_next;
            state <= more ? ST_PRD : ST_ERD;
          end
        end
        ST_ERD: begin
          state <= ST_ELD;
        end
        ST_ELD: begin
          if (out_load) begin
            out_item.result_value <= rdata_a;
            out_item.last_out     <= idx_last;
            out_item.overflow     <= run_ovf;
            if (idx_last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + ADDR_W'(1);
              state <= ST_ERD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/parity_partition.sv
// Odd-before-even partition of a word stream. Words arrive one per transfer
// and are buffered up to DEPTH (64) entries; words beyond that are dropped
// and every result of that run carries overflow. A transfer with last_in
// closes the run: the buffer is partitioned in place with two pointers
// closing in from both ends, then every buffered word is sent out with
// last_out on the final one. The front end takes one word per cycle, while
// the queue is not full, into a four-entry command queue; the back end, when
// idle, stores one word per cycle from it into its single-write-port buffer.
// A run of n words then takes at most n - 1 pointer steps, each a read
// (ST_PRD) and an evaluation (ST_PEVAL), plus ST_PSWAP when the step swaps,
// since both halves of a swap go through the one write port; each word is
// then emitted through ST_ERD and ST_ELD. The next run is accepted while the
// current one is still being processed, until the queue fills.
module parity_partition (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ppart_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppart_pkg::out_item_t out_item
);
  import ppart_pkg::*;

  logic          q_push;
  logic          q_pop;
  cmd_t          q_cmd;
  cmd_t          q_head;
  queue_status_t q_status;

  ppart_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_status.full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  ppart_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  ppart_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("command pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("command popped from an empty queue");

  a_dropped_flags_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_cmd.store |-> q_cmd.overflow)
    else $error("dropped word not flagged as overflow");

endmodule
